// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define LPSA_ASSERT_IMP(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication
`define LPSA_ASSERT_NXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define LPSA_ASSERT_IMP(lbl, clk, rstn, pre, post)
`define LPSA_ASSERT_NXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ===== hw/rtl/lpsa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpsa_pkg
// Types and constants of the linear probe score accumulator.
// ----------------------------------------------------------------------------
package lpsa_pkg;

    localparam int KEY_W   = 40;
    localparam int SCORE_W = 32;
    localparam int TERM_W  = 16;
    localparam int HWORDS  = 256;
    localparam int HIDX_W  = 8;
    localparam int SLOT_OW = 10;
    localparam int ENTRY_W = KEY_W + TERM_W + SCORE_W;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_LOAD = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        OUT_INSERT = 2'd0,
        OUT_ACCUM  = 2'd1,
        OUT_FULL   = 2'd2,
        OUT_LOAD   = 2'd3
    } t_outcome;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_START,
        ST_PROBE
    } t_state;

    // classified transaction as queued between front and back
    typedef struct packed {
        t_op               op;
        logic [KEY_W-1:0]  key;
        logic [SCORE_W-1:0] score;
        logic [HIDX_W-1:0] widx;
        logic [31:0]       wval;
    } t_item;

endpackage
`default_nettype wire

// ===== hw/rtl/lpsa_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== hw/rtl/lpsa_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpsa_front
// Accepts input transactions, derives the signed score and queues them
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module lpsa_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_clearing,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_operation,
    input  wire logic [39:0]           i_doc_key,
    input  wire logic [7:0]            i_score_byte,
    input  wire logic [7:0]            i_word_index,
    input  wire logic [31:0]           i_word_value,
    output logic                       o_q_valid,
    output lpsa_pkg::t_item            o_q_item,
    input  wire logic                  i_q_pop
);
    import lpsa_pkg::*;

    t_item       r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_item       item;
    logic [SCORE_W-1:0] mag;
    logic        push, pop;

    // score = 255 - byte, negated for even keys
    assign mag = SCORE_W'(8'd255 - i_score_byte);

    always_comb begin
        item.op    = t_op'(i_operation);
        item.key   = i_doc_key;
        item.score = i_doc_key[0] ? mag : (SCORE_W'(0) - mag);
        item.widx  = i_word_index;
        item.wval  = i_word_value;
    end

    assign o_in_ready = (r_cnt != 2'd2) && !i_clearing;
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_q_pop && (r_cnt != 2'd0);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_q[r_rp];

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/lpsa_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpsa_back
// Executes queued transactions: hash word loads and linear-probe inserts or
// accumulations into the slot RAM. Runs the clearing pass after reset.
// ----------------------------------------------------------------------------
module lpsa_back #(
    parameter int SLOTS = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire lpsa_pkg::t_item    i_q_item,
    output logic                    o_q_pop,
    input  wire logic [15:0]        i_term_mask,
    output logic                    o_clearing,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [9:0]              o_slot,
    output logic signed [31:0]      o_slot_score,
    output logic [15:0]             o_slot_terms,
    output logic [1:0]              o_outcome
);
    import lpsa_pkg::*;

    localparam int SW    = $clog2(SLOTS);
    localparam int CLR_N = (SLOTS > HWORDS) ? SLOTS : HWORDS;
    localparam int CW    = $clog2(CLR_N);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_clr, n_clr;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [SCORE_W-1:0]  r_score, n_score;
    logic [SW-1:0]       r_n, n_n, r_start, n_start, r_tries, n_tries;
    logic                r_out_valid, n_out_valid;
    logic [SLOT_OW-1:0]  r_slot, n_slot;
    logic [SCORE_W-1:0]  r_oscore, n_oscore;
    logic [TERM_W-1:0]   r_terms, n_terms;
    t_outcome            r_outcome, n_outcome;

    // RAM ports
    logic                h_we, h_re;
    logic [HIDX_W-1:0]   h_waddr, h_raddr;
    logic [31:0]         h_wdata, h_rdata;
    logic                s_we, s_re;
    logic [SW-1:0]       s_waddr, s_raddr;
    logic [ENTRY_W-1:0]  s_wdata, s_rdata;

    // probe datapath
    logic [KEY_W-1:0]    hx;
    logic [SW-1:0]       start, n_wrap;
    logic [SCORE_W-1:0]  e_score, sum;
    logic [TERM_W-1:0]   e_terms;
    logic [KEY_W-1:0]    e_key;
    logic                clr_slot, clr_hash;

    lpsa_ram #(.WIDTH(32), .DEPTH(HWORDS)) u_hash_ram (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_re(h_re), .i_raddr(h_raddr), .o_rdata(h_rdata)
    );

    lpsa_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_slot_ram (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_re(s_re), .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    // start slot from key and hash word
    assign hx     = r_key ^ {{(KEY_W-32){1'b0}}, h_rdata};
    assign start  = hx[SW-1:0] & SW'(SLOTS - 1);
    assign n_wrap = (r_n == SW'(SLOTS - 1)) ? '0 : r_n + 1'b1;

    // slot entry fields
    assign e_score = s_rdata[SCORE_W-1:0];
    assign e_terms = s_rdata[SCORE_W +: TERM_W];
    assign e_key   = s_rdata[SCORE_W+TERM_W +: KEY_W];
    assign sum     = e_score + r_score;

    assign clr_slot = ({1'b0, r_clr} < (CW+1)'(SLOTS));
    assign clr_hash = ({1'b0, r_clr} < (CW+1)'(HWORDS));

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_key       = r_key;
        n_score     = r_score;
        n_n         = r_n;
        n_start     = r_start;
        n_tries     = r_tries;
        n_out_valid = r_out_valid && !i_out_ready;
        n_slot      = r_slot;
        n_oscore    = r_oscore;
        n_terms     = r_terms;
        n_outcome   = r_outcome;
        o_q_pop     = 1'b0;
        h_we        = 1'b0;
        h_waddr     = r_clr[HIDX_W-1:0];
        h_wdata     = '0;
        h_re        = 1'b0;
        h_raddr     = r_key[HIDX_W-1:0];
        s_we        = 1'b0;
        s_waddr     = r_n;
        s_wdata     = '0;
        s_re        = 1'b0;
        s_raddr     = start;

        unique case (r_state)
            ST_CLEAR: begin
                h_we    = clr_hash;
                s_we    = clr_slot;
                s_waddr = r_clr[SW-1:0];
                n_clr   = r_clr + 1'b1;
                if (r_clr == CW'(CLR_N - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // take work when the result register is free or draining
                if (i_q_valid && (!r_out_valid || i_out_ready)) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.op == OP_LOAD) begin
                        h_we        = 1'b1;
                        h_waddr     = i_q_item.widx;
                        h_wdata     = i_q_item.wval;
                        n_out_valid = 1'b1;
                        n_slot      = '0;
                        n_oscore    = '0;
                        n_terms     = '0;
                        n_outcome   = OUT_LOAD;
                    end else begin
                        n_key   = i_q_item.key;
                        n_score = i_q_item.score;
                        n_state = ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                h_re    = 1'b1;
                n_state = ST_START;
            end
            ST_START: begin
                s_re    = 1'b1;
                s_raddr = start;
                n_n     = start;
                n_start = start;
                n_tries = '0;
                n_state = ST_PROBE;
            end
            ST_PROBE: begin
                if (e_score == '0) begin
                    // empty slot: insert
                    s_we        = 1'b1;
                    s_wdata     = {r_key, i_term_mask, r_score};
                    n_out_valid = 1'b1;
                    n_slot      = SLOT_OW'({{SLOT_OW{1'b0}}, r_n});
                    n_oscore    = r_score;
                    n_terms     = i_term_mask;
                    n_outcome   = OUT_INSERT;
                    n_state     = ST_IDLE;
                end else if (e_key == r_key) begin
                    // same key: accumulate
                    s_we        = 1'b1;
                    s_wdata     = {r_key, e_terms | i_term_mask, sum};
                    n_out_valid = 1'b1;
                    n_slot      = SLOT_OW'({{SLOT_OW{1'b0}}, r_n});
                    n_oscore    = sum;
                    n_terms     = e_terms | i_term_mask;
                    n_outcome   = OUT_ACCUM;
                    n_state     = ST_IDLE;
                end else if (r_tries == SW'(SLOTS - 1)) begin
                    // every slot held another key
                    n_out_valid = 1'b1;
                    n_slot      = SLOT_OW'({{SLOT_OW{1'b0}}, r_start});
                    n_oscore    = '0;
                    n_terms     = '0;
                    n_outcome   = OUT_FULL;
                    n_state     = ST_IDLE;
                end else begin
                    s_re    = 1'b1;
                    s_raddr = n_wrap;
                    n_n     = n_wrap;
                    n_tries = r_tries + 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_score   <= n_score;
        r_n       <= n_n;
        r_start   <= n_start;
        r_tries   <= n_tries;
        r_slot    <= n_slot;
        r_oscore  <= n_oscore;
        r_terms   <= n_terms;
        r_outcome <= n_outcome;
    end

    assign o_clearing   = (r_state == ST_CLEAR);
    assign o_out_valid  = r_out_valid;
    assign o_slot       = r_slot;
    assign o_slot_score = r_oscore;
    assign o_slot_terms = r_terms;
    assign o_outcome    = r_outcome;

endmodule
`default_nettype wire

// ===== hw/rtl/linear_probe_score_accumulator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_score_accumulator
// Accumulates scored postings into an open-addressed, linearly probed slot
// table; also loads the 256-word start hash table.
// ----------------------------------------------------------------------------
// Channel  Handshake                  Payload
// input    i_in_valid / o_in_ready    operation, doc_key, score_byte,
//                                     word_index, word_value
// output   o_out_valid / i_out_ready  slot, slot_score, slot_terms, outcome
// config   i_cfg_we                   i_cfg_wdata (term_mask)
//
// A load completes in the idle state; an add goes through the HASH and START
// states, then probes one slot per cycle on the slot RAM's single read port.
// After reset a pass clearing all slot and hash words runs with o_in_ready
// low. A two-entry queue decouples input acceptance from probing; the back
// end starts a transaction only while the result register is empty or is
// being accepted in the same cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module linear_probe_score_accumulator #(
    parameter int SLOTS = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_wdata,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_operation,
    input  wire logic [39:0]        i_doc_key,
    input  wire logic [7:0]         i_score_byte,
    input  wire logic [7:0]         i_word_index,
    input  wire logic [31:0]        i_word_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [9:0]              o_slot,
    output logic signed [31:0]      o_slot_score,
    output logic [15:0]             o_slot_terms,
    output logic [1:0]              o_outcome
);
    import lpsa_pkg::*;

    logic [TERM_W-1:0] r_term_mask;
    logic              clearing, q_valid, q_pop;
    t_item             q_item;
    logic              out_load, out_full;

    // term mask register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_mask <= TERM_W'(1);
        end else if (i_cfg_we) begin
            r_term_mask <= i_cfg_wdata;
        end
    end

    lpsa_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clearing(clearing),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_operation(i_operation), .i_doc_key(i_doc_key),
        .i_score_byte(i_score_byte), .i_word_index(i_word_index),
        .i_word_value(i_word_value),
        .o_q_valid(q_valid), .o_q_item(q_item), .i_q_pop(q_pop)
    );

    lpsa_back #(.SLOTS(SLOTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .i_q_item(q_item), .o_q_pop(q_pop),
        .i_term_mask(r_term_mask), .o_clearing(clearing),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_slot(o_slot), .o_slot_score(o_slot_score),
        .o_slot_terms(o_slot_terms), .o_outcome(o_outcome)
    );

    // result kinds watched below
    assign out_load = o_out_valid && (o_outcome == OUT_LOAD);
    assign out_full = o_out_valid && (o_outcome == OUT_FULL);

    // no input transactions during the clearing pass
    `LPSA_ASSERT_IMP(a_clear_blocks, i_clk, i_rst_n, clearing, !o_in_ready)
    // word loads report slot and score zero
    `LPSA_ASSERT_IMP(a_load_zero, i_clk, i_rst_n, out_load, o_slot == 10'd0 && o_slot_score == 32'sd0)
    // a full table reports no score or terms
    `LPSA_ASSERT_IMP(a_full_zero, i_clk, i_rst_n, out_full, o_slot_score == 32'sd0 && o_slot_terms == 16'd0)
    // a reset always starts the clearing pass
    `LPSA_ASSERT_NXT(a_reset_clear, i_clk, i_rst_n, $past(!i_rst_n), !o_in_ready)

endmodule
`default_nettype wire
